### design/pps_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants, controller states and the command/status structs that join
// the scheduler controller to its datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MaxProcs  = 16;
  localparam int SlotW     = $clog2(MaxProcs);
  localparam int CountW    = $clog2(MaxProcs + 1);

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusLate  = 2'd2;

  localparam logic       OpLoad = 1'b0;
  localparam logic       OpTick = 1'b1;

  localparam logic [0:0] RegSwitchCost = 1'b0;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDispatch,
    StRun,
    StPreempt,
    StOut
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // accept a load word
    logic tick_begin;  // latch start of tick
    logic scan_clear;  // reset scan pointer and found flag
    logic scan_step;   // examine one slot
    logic dispatch;    // dispatch best
    logic run;         // run current for one tick
    logic preempt;     // preempt current with best
    logic idle_tick;   // advance time without running
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ticking;
    logic cur_valid;
    logic scan_done;
    logic found;
    logic better;      // best prio strictly above current
    logic run_fin;     // current completes at this tick
  } stat_t;

endpackage

### design/pps_datapath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Process table, time counter, serial best-ready scan and result register.
// ----------------------------------------------------------------------------
module pps_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  pps_pkg::cmd_t           cmd,
  output pps_pkg::stat_t          stat,
  input  logic [7:0]              switch_cost,
  input  logic [7:0]              proc_id,
  input  logic [15:0]             arrival,
  input  logic [15:0]             burst,
  input  logic [7:0]              prio,
  input  logic                    skip_cur,
  output logic [1:0]              res_status,
  output logic                    res_running_valid,
  output logic [7:0]              res_running_id,
  output logic                    res_finished,
  output logic [7:0]              res_finished_id,
  output logic [15:0]             res_turnaround,
  output logic [15:0]             res_waiting,
  output logic [15:0]             res_response
);

  logic [7:0]  e_id      [pps_pkg::MaxProcs];
  logic [15:0] e_arr     [pps_pkg::MaxProcs];
  logic [15:0] e_rem     [pps_pkg::MaxProcs];
  logic [7:0]  e_prio    [pps_pkg::MaxProcs];
  logic [15:0] e_stop    [pps_pkg::MaxProcs];
  logic [15:0] e_wait    [pps_pkg::MaxProcs];
  logic [15:0] e_resp    [pps_pkg::MaxProcs];
  logic [15:0] e_charge  [pps_pkg::MaxProcs];
  logic [pps_pkg::MaxProcs-1:0] e_started, e_stopped, e_done;

  logic [pps_pkg::CountW-1:0] count;
  logic [pps_pkg::CountW-1:0] ptr;
  logic [pps_pkg::SlotW-1:0]  cur, best;
  logic                       cur_valid, found, ticking;
  logic [15:0]                now;

  logic [pps_pkg::SlotW-1:0]  pslot;
  logic                       cand;
  logic [15:0]                rem_dec, now_inc, d_arr, d_stop;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign pslot   = ptr[pps_pkg::SlotW-1:0];
  assign cand    = !e_done[pslot] && (e_arr[pslot] <= now)
                   && !(skip_cur && pslot == cur);
  assign rem_dec = (e_rem[cur] != 16'd0) ? e_rem[cur] - 16'd1 : 16'd0;
  assign now_inc = (now != 16'hFFFF) ? now + 16'd1 : now;
  assign d_arr   = now - e_arr[best];
  assign d_stop  = now - e_stop[best];

  assign stat.ticking   = ticking;
  assign stat.cur_valid = cur_valid;
  assign stat.scan_done = (ptr >= count);
  assign stat.found     = found;
  assign stat.better    = found && (e_prio[best] > e_prio[cur]);
  assign stat.run_fin   = (rem_dec == 16'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur_valid <= 1'b0;
      now       <= '0;
      ticking   <= 1'b0;
      e_started <= '0;
      e_stopped <= '0;
      e_done    <= '0;
      found     <= 1'b0;
      ptr       <= '0;
    end else begin
      if (cmd.load) begin
        res_running_valid <= 1'b0;
        res_running_id    <= '0;
        res_finished      <= 1'b0;
        res_finished_id   <= '0;
        res_turnaround    <= '0;
        res_waiting       <= '0;
        res_response      <= '0;
        if (ticking) begin
          res_status <= pps_pkg::StatusLate;
        end else if (count >= pps_pkg::CountW'(pps_pkg::MaxProcs)) begin
          res_status <= pps_pkg::StatusFull;
        end else begin
          res_status                   <= pps_pkg::StatusOk;
          e_id[count[pps_pkg::SlotW-1:0]]     <= proc_id;
          e_arr[count[pps_pkg::SlotW-1:0]]    <= arrival;
          e_rem[count[pps_pkg::SlotW-1:0]]    <= (burst == 16'd0) ? 16'd1 : burst;
          e_prio[count[pps_pkg::SlotW-1:0]]   <= prio;
          e_stop[count[pps_pkg::SlotW-1:0]]   <= '0;
          e_wait[count[pps_pkg::SlotW-1:0]]   <= '0;
          e_resp[count[pps_pkg::SlotW-1:0]]   <= '0;
          e_charge[count[pps_pkg::SlotW-1:0]] <= '0;
          e_started[count[pps_pkg::SlotW-1:0]] <= 1'b0;
          e_stopped[count[pps_pkg::SlotW-1:0]] <= 1'b0;
          e_done[count[pps_pkg::SlotW-1:0]]    <= 1'b0;
          count <= count + 1'b1;
        end
      end
      if (cmd.tick_begin) begin
        ticking           <= 1'b1;
        res_status        <= pps_pkg::StatusOk;
        res_running_valid <= 1'b0;
        res_running_id    <= '0;
        res_finished      <= 1'b0;
        res_finished_id   <= '0;
        res_turnaround    <= '0;
        res_waiting       <= '0;
        res_response      <= '0;
      end
      if (cmd.scan_clear) begin
        ptr   <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_step) begin
        // Strictly greater keeps the lowest slot on a tie.
        if (cand && (!found || e_prio[pslot] > e_prio[best])) begin
          best  <= pslot;
          found <= 1'b1;
        end
        ptr <= ptr + 1'b1;
      end
      if (cmd.dispatch || cmd.preempt) begin
        if (e_stopped[best]) begin
          e_wait[best] <= sat_add(e_wait[best], d_stop);
        end else if (!e_started[best]) begin
          e_resp[best] <= d_arr;
          e_wait[best] <= sat_add(e_wait[best], d_arr);
        end
        e_started[best] <= 1'b1;
        cur             <= best;
        cur_valid       <= 1'b1;
      end
      if (cmd.preempt) begin
        e_charge[cur]  <= sat_add(e_charge[cur], {8'd0, switch_cost});
        e_stop[cur]    <= now;
        e_stopped[cur] <= 1'b1;
      end
      if (cmd.idle_tick) begin
        now <= now_inc;
      end
      if (cmd.run) begin
        res_running_valid <= 1'b1;
        res_running_id    <= e_id[cur];
        e_rem[cur]        <= rem_dec;
        now               <= now_inc;
        if (rem_dec == 16'd0) begin
          e_done[cur]     <= 1'b1;
          cur_valid       <= 1'b0;
          res_finished    <= 1'b1;
          res_finished_id <= e_id[cur];
          res_turnaround  <= sat_add(now_inc - e_arr[cur], e_charge[cur]);
          res_waiting     <= sat_add(e_wait[cur], e_charge[cur]);
          res_response    <= e_resp[cur];
        end
      end
    end
  end

endmodule

### design/pps_control.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences load, scan, dispatch, run and preempt steps for each word.
// ----------------------------------------------------------------------------
module pps_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           op,
  output logic           out_valid,
  input  logic           out_ready,
  input  pps_pkg::stat_t stat,
  output pps_pkg::cmd_t  cmd,
  output logic           skip_cur
);

  pps_pkg::state_t state, state_next;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pps_pkg::StIdle: begin
        if (accept) begin
          if (op == pps_pkg::OpLoad) state_next = pps_pkg::StOut;
          else if (stat.cur_valid)   state_next = pps_pkg::StRun;
          else                       state_next = pps_pkg::StScan;
        end
      end
      pps_pkg::StScan: begin
        if (stat.scan_done) state_next = pps_pkg::StDispatch;
      end
      pps_pkg::StDispatch: begin
        state_next = stat.found ? pps_pkg::StRun : pps_pkg::StOut;
      end
      pps_pkg::StRun: begin
        state_next = stat.run_fin ? pps_pkg::StOut : pps_pkg::StPreempt;
      end
      pps_pkg::StPreempt: begin
        if (stat.scan_done) state_next = pps_pkg::StOut;
      end
      pps_pkg::StOut: begin
        if (out_ready) state_next = pps_pkg::StIdle;
      end
      default: state_next = pps_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    skip_cur  = 1'b0;
    case (state)
      pps_pkg::StIdle: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.load       = (op == pps_pkg::OpLoad);
          cmd.tick_begin = (op == pps_pkg::OpTick);
          cmd.scan_clear = (op == pps_pkg::OpTick);
        end
      end
      pps_pkg::StScan: begin
        cmd.scan_step = !stat.scan_done;
      end
      pps_pkg::StDispatch: begin
        cmd.dispatch  = stat.found;
        cmd.idle_tick = !stat.found;
      end
      pps_pkg::StRun: begin
        cmd.run        = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      pps_pkg::StPreempt: begin
        // Scan excludes the current slot, then swap in a strictly better one.
        skip_cur      = 1'b1;
        cmd.scan_step = !stat.scan_done;
        cmd.preempt   = stat.scan_done && stat.better;
      end
      pps_pkg::StOut: begin
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### design/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Loads a process table and, per tick word, runs the best ready process.
// ----------------------------------------------------------------------------
//   Channel  Handshake           Contents
//   in       in_valid/in_ready   op, proc_id, arrival, burst, prio
//   out      out_valid/out_ready status, running and completion fields
//   cfg      APB write/read      switch_cost at address 0
//
// A load word needs no scan. A tick that must first pick a process runs the serial
// one-slot-a-cycle scans over the N loaded entries for both dispatch and preemption;
// a tick that keeps the running process runs only the preemption scan.
// One word is in flight at a time; the result is held until out_ready.
// Reset is synchronous and clears time, the table count and all flags.
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  proc_id,
  input  logic [15:0] arrival,
  input  logic [15:0] burst,
  input  logic [7:0]  prio,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        running_valid,
  output logic [7:0]  running_id,
  output logic        finished,
  output logic [7:0]  finished_id,
  output logic [15:0] turnaround,
  output logic [15:0] waiting,
  output logic [15:0] response
);

  logic [7:0]     switch_cost;
  pps_pkg::cmd_t  cmd;
  pps_pkg::stat_t stat;
  logic           skip_cur;

  assign pready = 1'b1;
  assign prdata = (paddr == pps_pkg::RegSwitchCost) ? {24'd0, switch_cost} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_cost <= '0;
    end else if (psel && penable && pwrite && paddr == pps_pkg::RegSwitchCost) begin
      switch_cost <= pwdata[7:0];
    end
  end

  pps_control u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd),
    .skip_cur(skip_cur)
  );

  pps_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .switch_cost(switch_cost),
    .proc_id(proc_id), .arrival(arrival), .burst(burst), .prio(prio),
    .skip_cur(skip_cur), .res_status(status), .res_running_valid(running_valid),
    .res_running_id(running_id), .res_finished(finished),
    .res_finished_id(finished_id), .res_turnaround(turnaround),
    .res_waiting(waiting), .res_response(response)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// Preemptive priority scheduler testbench
// Loads a process table, then streams tick words through the scheduler while
// a scoreboard predicts each result word and checks it field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  status;
    logic        running_valid;
    logic [7:0]  running_id;
    logic        finished;
    logic [7:0]  finished_id;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
  } sched_result_t;

  localparam logic [2:0] FlgStarted = 3'b001;
  localparam logic [2:0] FlgStopped = 3'b010;
  localparam logic [2:0] FlgDone    = 3'b100;

  class sched_scoreboard;
    logic [7:0]    ent_id     [pps_pkg::MaxProcs];
    logic [15:0]   ent_arr    [pps_pkg::MaxProcs];
    logic [15:0]   ent_rem    [pps_pkg::MaxProcs];
    logic [7:0]    ent_prio   [pps_pkg::MaxProcs];
    logic [15:0]   ent_stop   [pps_pkg::MaxProcs];
    logic [2:0]    ent_flags  [pps_pkg::MaxProcs];
    logic [15:0]   ent_wait   [pps_pkg::MaxProcs];
    logic [15:0]   ent_resp   [pps_pkg::MaxProcs];
    logic [15:0]   ent_charge [pps_pkg::MaxProcs];
    int            ent_count;
    bit            cur_valid;
    int            cur_slot;
    int            now_t;
    bit            ticking;
    logic [7:0]    switch_cost;
    sched_result_t expected_q[$];
    int            errors;

    function new();
      ent_count = 0;
      cur_valid = 0;
      cur_slot = 0;
      now_t = 0;
      ticking = 0;
      switch_cost = 0;
      errors = 0;
    endfunction

    function logic [15:0] sat_add(int a, int b);
      return (a + b > 65535) ? 16'hffff : 16'(a + b);
    endfunction

    function void queue_result(sched_result_t r);
      expected_q = {expected_q, r};
    endfunction

    // Highest ready priority, lowest slot on ties; skip excludes one slot.
    function bit pick_best(int skip, output int slot);
      bit found;
      found = 0;
      slot = 0;
      for (int i = 0; i < ent_count; i++) begin
        if (i == skip || ent_flags[i][2] || int'(ent_arr[i]) > now_t) continue;
        if (!found || ent_prio[i] > ent_prio[slot]) begin
          slot = i;
          found = 1;
        end
      end
      return found;
    endfunction

    function void dispatch(int s);
      int d;
      if (ent_flags[s] & FlgStopped) begin
        ent_wait[s] = sat_add(ent_wait[s], now_t - int'(ent_stop[s]));
      end else if (!(ent_flags[s] & FlgStarted)) begin
        d = now_t - int'(ent_arr[s]);
        ent_resp[s] = 16'(d);
        ent_wait[s] = sat_add(ent_wait[s], d);
      end
      ent_flags[s] |= FlgStarted;
      cur_valid = 1;
      cur_slot = s;
    endfunction

    function void note_word(logic op_i, logic [7:0] id_i, logic [15:0] arr_i,
                            logic [15:0] burst_i, logic [7:0] prio_i);
      sched_result_t r;
      int s;
      int c;
      r = '{default: 0};
      if (op_i == pps_pkg::OpLoad) begin
        if (ticking) begin
          r.status = pps_pkg::StatusLate;
        end else if (ent_count >= pps_pkg::MaxProcs) begin
          r.status = pps_pkg::StatusFull;
        end else begin
          s = ent_count;
          ent_id[s] = id_i;
          ent_arr[s] = arr_i;
          ent_rem[s] = (burst_i == 0) ? 16'd1 : burst_i;
          ent_prio[s] = prio_i;
          ent_stop[s] = 0;
          ent_flags[s] = 0;
          ent_wait[s] = 0;
          ent_resp[s] = 0;
          ent_charge[s] = 0;
          ent_count = s + 1;
        end
        queue_result(r);
        return;
      end
      ticking = 1;
      if (!cur_valid && pick_best(pps_pkg::MaxProcs, s)) dispatch(s);
      if (!cur_valid) begin
        if (now_t < 65535) now_t++;
        queue_result(r);
        return;
      end
      c = cur_slot;
      r.running_valid = 1;
      r.running_id = ent_id[c];
      if (ent_rem[c] > 0) ent_rem[c]--;
      if (now_t < 65535) now_t++;
      if (ent_rem[c] == 0) begin
        ent_flags[c] |= FlgDone;
        cur_valid = 0;
        r.finished = 1;
        r.finished_id = ent_id[c];
        r.turnaround = sat_add(now_t - int'(ent_arr[c]), ent_charge[c]);
        r.waiting = sat_add(ent_wait[c], ent_charge[c]);
        r.response = ent_resp[c];
      end else if (pick_best(c, s) && ent_prio[s] > ent_prio[c]) begin
        ent_charge[c] = sat_add(ent_charge[c], switch_cost);
        ent_stop[c] = 16'(now_t);
        ent_flags[c] |= FlgStopped;
        dispatch(s);
      end
      queue_result(r);
    endfunction

    function void cmp(string name, int e, int a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_word(sched_result_t a);
      sched_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no expected word pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("status", e.status, a.status);
      cmp("running_valid", e.running_valid, a.running_valid);
      cmp("running_id", e.running_id, a.running_id);
      cmp("finished", e.finished, a.finished);
      cmp("finished_id", e.finished_id, a.finished_id);
      cmp("turnaround", e.turnaround, a.turnaround);
      cmp("waiting", e.waiting, a.waiting);
      cmp("response", e.response, a.response);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [0:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic        op = 0;
  logic [7:0]  proc_id = 0;
  logic [15:0] arrival = 0;
  logic [15:0] burst = 0;
  logic [7:0]  prio = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic        running_valid;
  logic [7:0]  running_id;
  logic        finished;
  logic [7:0]  finished_id;
  logic [15:0] turnaround;
  logic [15:0] waiting;
  logic [15:0] response;

  sched_scoreboard sb = new();
  bit quiet = 0;
  int out_stall = 0;

  preemptive_priority_scheduler dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    sched_result_t act;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(op, proc_id, arrival, burst, prio);
      if (out_valid && out_ready) begin
        act.status = status;
        act.running_valid = running_valid;
        act.running_id = running_id;
        act.finished = finished;
        act.finished_id = finished_id;
        act.turnaround = turnaround;
        act.waiting = waiting;
        act.response = response;
        sb.check_word(act);
      end
    end
  end

  // Receiver stalls come in bursts, except in the quiet tail of the run.
  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1;
    end else if (out_stall > 0) begin
      out_ready <= 0;
      out_stall <= out_stall - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 0;
      out_stall <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1;
    end
  end

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_word(logic o, logic [7:0] i, logic [15:0] a, logic [15:0] b,
                           logic [7:0] p);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    op <= o;
    proc_id <= i;
    arrival <= a;
    burst <= b;
    prio <= p;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_rand_load();
    send_word(pps_pkg::OpLoad, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_tick();
    send_word(pps_pkg::OpTick, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cost(logic [7:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= pps_pkg::RegSwitchCost;
    pwdata <= {24'($urandom_range(0, 16777215)), v};
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.switch_cost = v;
    @(negedge clk);
    psel <= 1;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.cmp("prdata", sb.switch_cost, prdata[7:0]);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    write_cost(8'd0);

    // Zero burst, a process that never arrives, and a long low-priority job.
    send_word(pps_pkg::OpLoad, 8'd0, 16'd0, 16'd0, 8'd0);
    send_word(pps_pkg::OpLoad, 8'd255, 16'hffff, 16'hffff, 8'd255);
    send_word(pps_pkg::OpLoad, 8'd7, 16'd0, 16'hffff, 8'd0);
    for (int k = 3; k < pps_pkg::MaxProcs; k++)
      send_word(pps_pkg::OpLoad, 8'($urandom), 16'($urandom_range(0, 1300)),
                16'($urandom_range(1, 60)), 8'($urandom_range(1, 8) * 31));
    // The table is full now.
    send_rand_load();
    repeat (5) send_tick();
    // Loads after ticking began are refused.
    send_rand_load();

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: write_cost(8'd255);
        1: write_cost(8'($urandom_range(1, 254)));
        2: write_cost(8'd0);
        default: write_cost(8'd255);
      endcase
      if (ph == 3) quiet = 1;
      for (int n = 0; n < 350; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_rand_load();
        else
          send_tick();
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

### preemptive_priority_scheduler.f
design/pps_pkg.sv
design/pps_datapath.sv
design/pps_control.sv
design/preemptive_priority_scheduler.sv
test/tb.sv
